FILE: rtl/potential_field_steering_defines.svh
// assertion macros shared by the potential field steering checker
// no dependencies; expects clk_i and rst_ni in the using scope
`ifndef POTENTIAL_FIELD_STEERING_DEFINES_SVH
`define POTENTIAL_FIELD_STEERING_DEFINES_SVH

// same-cycle implication
`define PFS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("potential field steering check failed");

// next-cycle implication
`define PFS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("potential field steering check failed");

`endif

FILE: rtl/pfs_pkg.sv
// shared types, codes and constants of the potential field steering block
// no dependencies
package pfs_pkg;

  localparam int MUL_BITS     = 25;
  localparam int UX_BITS      = 25;
  localparam int CORDIC_STEPS = 20;
  localparam int IT_BITS      = 5;
  localparam int CORDIC_BITS  = 35;
  localparam int Z_BITS       = 24;
  localparam int HALF_PI_Q20  = 1647099;
  localparam int HEAD_LIMIT   = 25736;
  localparam int CFG_BITS     = 16;

  localparam logic       CMD_GOAL    = 1'b0;
  localparam logic       CMD_POINT   = 1'b1;
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_GOAL = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  typedef enum logic [1:0] {
    REG_ATTRACT = 2'd0,
    REG_REPEL   = 2'd1,
    REG_TURN    = 2'd2,
    REG_CRUISE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic start;
    logic root;
  } pfs_unit_req_t;

  // arctan(2^-i) in 1/2^20 rad
  function automatic logic [19:0] cordic_atan(input logic [IT_BITS-1:0] idx);
    logic [19:0] a;
    unique case (idx)
      5'd0:    a = 20'd823550;
      5'd1:    a = 20'd486170;
      5'd2:    a = 20'd256879;
      5'd3:    a = 20'd130396;
      5'd4:    a = 20'd65451;
      5'd5:    a = 20'd32757;
      5'd6:    a = 20'd16383;
      5'd7:    a = 20'd8192;
      5'd8:    a = 20'd4096;
      5'd9:    a = 20'd2048;
      5'd10:   a = 20'd1024;
      5'd11:   a = 20'd512;
      5'd12:   a = 20'd256;
      5'd13:   a = 20'd128;
      5'd14:   a = 20'd64;
      5'd15:   a = 20'd32;
      5'd16:   a = 20'd16;
      5'd17:   a = 20'd8;
      5'd18:   a = 20'd4;
      5'd19:   a = 20'd2;
      default: a = 20'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/potential_field_steering.sv
// top level of the potential field steering block: sequencer, accumulators,
// cordic heading and drive command; depends on pfs_pkg and pfs_unit
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------------
//   in       | in_valid_i / in_stall_o  | command_i pos_x_i pos_y_i last_i
//   out      | out_valid_o / out_stall_i| force_x_o force_y_o heading_o
//            |                          | angular_rate_o linear_speed_o status_o
//   cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i cfg_data_i
//
// in_stall_o is high while a request is in work. a point request uses the shared divide /
// square root unit for one root and four divides, a goal request for one root and two
// divides; a request with last then runs 20 cordic steps. the result register lets the
// next request in while a result still waits. async active-low reset, no clearing pass.
module potential_field_steering import pfs_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ACC_BITS   = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           force_x_o,
  output logic signed [31:0]           force_y_o,
  output logic signed [15:0]           heading_o,
  output logic signed [17:0]           angular_rate_o,
  output logic [11:0]                  linear_speed_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [CFG_BITS-1:0]          cfg_data_i
);

  localparam int C         = COORD_BITS;
  localparam int NW        = (2 * C + 16 > 45) ? 2 * C + 16 : 45;
  localparam int DVW       = 2 * C;
  localparam int ROOT_BITS = C + 8;
  localparam int TW        = ((ACC_BITS > 46) ? ACC_BITS : 46) + 1;
  localparam int EW        = (ACC_BITS > 32) ? ACC_BITS : 33;
  localparam int PW        = 2 * MUL_BITS;

  localparam logic signed [TW-1:0] ACC_HI = (TW'(1) << (ACC_BITS - 1)) - TW'(1);
  localparam logic signed [TW-1:0] ACC_LO = ~ACC_HI;
  localparam logic signed [EW-1:0] F_HI   = EW'(33'sh0_7FFF_FFFF);
  localparam logic signed [EW-1:0] F_LO   = ~F_HI;
  localparam logic signed [Z_BITS-1:0] H_HI = Z_BITS'(HEAD_LIMIT);
  localparam logic signed [Z_BITS-1:0] H_LO = -H_HI;
  localparam logic signed [Z_BITS-1:0] HPI  = Z_BITS'(HALF_PI_Q20);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_X, S_SQ_Y, S_CHECK, S_ROOT, S_DIV_U_GO, S_DIV_U, S_MUL_G,
    S_GAIN, S_DIV_F, S_CLAMP, S_CORDIC, S_ROUND, S_RATE, S_RATE_W, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [15:0] attract_gain_q, repel_gain_q;
  logic [9:0]  turn_gain_q;
  logic [11:0] cruise_speed_q;

  // request context
  logic                cmd_q, last_q, x_neg_q, y_neg_q, x_pos_q, y_pos_q, sel_q;
  logic [C-1:0]        ax_q, ay_q;
  logic [DVW-1:0]      d2_q;
  logic [ROOT_BITS-1:0] dd_q;
  logic [UX_BITS-1:0]  ux_q;

  logic signed [ACC_BITS-1:0] sum_x_q, sum_y_q;
  logic                goal_flag_q, sat_flag_q;

  // emission
  logic signed [31:0]          rx_q, ry_q;
  logic                        hit_q, zero_q;
  logic signed [CORDIC_BITS-1:0] cx_q, cy_q;
  logic signed [Z_BITS-1:0]    z_q;
  logic [IT_BITS-1:0]          it_q;
  logic signed [15:0]          h_q;
  logic signed [17:0]          rate_q;

  logic                out_valid_q;
  logic signed [31:0]  out_fx_q, out_fy_q;
  logic signed [15:0]  out_h_q;
  logic signed [17:0]  out_rate_q;
  logic [11:0]         out_speed_q;
  logic [1:0]          out_status_q;

  // shared multiplier
  logic [MUL_BITS-1:0] mul_a, mul_b;
  logic [PW-1:0]       prod_q;

  // shared divide / root unit
  pfs_unit_req_t  unit_req;
  logic [NW-1:0]  unit_num, unit_q;
  logic [DVW-1:0] unit_den;
  logic           unit_done;

  logic [C-1:0]   ax_in, ay_in, axy_sel;
  logic [DVW-1:0] d2_sum;
  logic [PW:0]    prod_rnd;
  logic [TW-1:0]  mag_sel;
  logic signed [TW-1:0] term_s, term, sum_ext, new_sum;
  logic           flip, clip_hi, clip_lo;
  logic signed [ACC_BITS-1:0] acc_clamped, cur_sum;

  logic signed [EW-1:0] sx_e, sy_e;
  logic signed [31:0]   rx_c, ry_c;
  logic                 clip_x, clip_y;

  logic signed [CORDIC_BITS-1:0] sx, sy;
  logic signed [Z_BITS-1:0]      z_step, z_bias, z_sh;
  logic [14:0]                   h_mag;
  logic [16:0]                   rate_mag;
  logic                          out_free;

  assign ax_in   = pos_x_i[C-1] ? C'(-pos_x_i) : C'(pos_x_i);
  assign ay_in   = pos_y_i[C-1] ? C'(-pos_y_i) : C'(pos_y_i);
  assign axy_sel = sel_q ? ay_q : ax_q;
  assign d2_sum  = d2_q + prod_q[DVW-1:0];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQ_X: begin
        mul_a = MUL_BITS'(ax_q);
        mul_b = MUL_BITS'(ax_q);
      end
      S_SQ_Y: begin
        mul_a = MUL_BITS'(ay_q);
        mul_b = MUL_BITS'(ay_q);
      end
      S_MUL_G: begin
        mul_a = MUL_BITS'(cmd_q == CMD_GOAL ? attract_gain_q : repel_gain_q);
        mul_b = ux_q;
      end
      S_RATE: begin
        mul_a = MUL_BITS'(h_mag);
        mul_b = MUL_BITS'(turn_gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // divide / root request
  always_comb begin
    unit_req = '0;
    unit_num = '0;
    unit_den = '0;
    unique case (state_q)
      S_CHECK: begin
        unit_req.start = (d2_sum != '0);
        unit_req.root  = 1'b1;
        unit_num       = NW'(d2_sum) << (NW - 2 * C);
      end
      S_DIV_U_GO: begin
        unit_req.start = 1'b1;
        unit_num       = NW'(axy_sel) << 24;
        unit_den       = DVW'(dd_q);
      end
      S_GAIN: begin
        unit_req.start = (cmd_q == CMD_POINT);
        unit_num       = NW'({prod_q, 4'b0000}) + NW'(d2_q >> 1);
        unit_den       = d2_q;
      end
      default: begin
        unit_req = '0;
      end
    endcase
  end

  pfs_unit #(
    .NW      (NW),
    .DVW     (DVW),
    .SQ_STEPS(ROOT_BITS)
  ) u_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (unit_req),
    .num_i (unit_num),
    .den_i (unit_den),
    .done_o(unit_done),
    .q_o   (unit_q)
  );

  // force term and saturating accumulate
  assign prod_rnd    = (PW + 1)'(prod_q) + (PW + 1)'(128);
  assign mag_sel     = (cmd_q == CMD_GOAL) ? TW'(prod_rnd >> 8) : TW'(unit_q);
  assign term_s      = $signed(mag_sel);
  assign flip        = (cmd_q == CMD_GOAL) ? (sel_q ? y_neg_q : x_neg_q)
                                           : (sel_q ? y_pos_q : x_pos_q);
  assign term        = flip ? -term_s : term_s;
  assign cur_sum     = sel_q ? sum_y_q : sum_x_q;
  assign sum_ext     = TW'(cur_sum);
  assign new_sum     = (cmd_q == CMD_GOAL) ? term : sum_ext + term;
  assign clip_hi     = new_sum > ACC_HI;
  assign clip_lo     = new_sum < ACC_LO;
  assign acc_clamped = clip_hi ? ACC_HI[ACC_BITS-1:0]
                     : (clip_lo ? ACC_LO[ACC_BITS-1:0] : new_sum[ACC_BITS-1:0]);

  // output saturation to 32 bits
  assign sx_e   = EW'(sum_x_q);
  assign sy_e   = EW'(sum_y_q);
  assign clip_x = (sx_e > F_HI) || (sx_e < F_LO);
  assign clip_y = (sy_e > F_HI) || (sy_e < F_LO);
  assign rx_c   = clip_x ? (sx_e[EW-1] ? F_LO[31:0] : F_HI[31:0]) : sx_e[31:0];
  assign ry_c   = clip_y ? (sy_e[EW-1] ? F_LO[31:0] : F_HI[31:0]) : sy_e[31:0];

  // cordic step and rounding
  assign sx       = cx_q >>> it_q;
  assign sy       = cy_q >>> it_q;
  assign z_step   = $signed(Z_BITS'(cordic_atan(it_q)));
  assign z_bias   = z_q + $signed(Z_BITS'(64));
  assign z_sh     = z_bias >>> 7;
  assign h_mag    = h_q[15] ? 15'(-h_q) : h_q[14:0];
  assign rate_mag = prod_rnd[24:8];
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_GOAL;
      last_q       <= 1'b0;
      x_neg_q      <= 1'b0;
      y_neg_q      <= 1'b0;
      x_pos_q      <= 1'b0;
      y_pos_q      <= 1'b0;
      sel_q        <= 1'b0;
      ax_q         <= '0;
      ay_q         <= '0;
      d2_q         <= '0;
      dd_q         <= '0;
      ux_q         <= '0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      goal_flag_q  <= 1'b0;
      sat_flag_q   <= 1'b0;
      rx_q         <= '0;
      ry_q         <= '0;
      hit_q        <= 1'b0;
      zero_q       <= 1'b0;
      cx_q         <= '0;
      cy_q         <= '0;
      z_q          <= '0;
      it_q         <= '0;
      h_q          <= '0;
      rate_q       <= '0;
      out_valid_q  <= 1'b0;
      out_fx_q     <= '0;
      out_fy_q     <= '0;
      out_h_q      <= '0;
      out_rate_q   <= '0;
      out_speed_q  <= '0;
      out_status_q <= STATUS_OK;
    end else begin
      // a new result in S_OUT takes the place of the one leaving
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= command_i;
            last_q  <= last_i;
            ax_q    <= ax_in;
            ay_q    <= ay_in;
            x_neg_q <= pos_x_i[C-1];
            y_neg_q <= pos_y_i[C-1];
            x_pos_q <= !pos_x_i[C-1] && (pos_x_i != '0);
            y_pos_q <= !pos_y_i[C-1] && (pos_y_i != '0);
            if (command_i == CMD_GOAL) begin
              sum_x_q     <= '0;
              sum_y_q     <= '0;
              goal_flag_q <= 1'b0;
              sat_flag_q  <= 1'b0;
            end
            state_q <= S_SQ_X;
          end
        end
        S_SQ_X: begin
          state_q <= S_SQ_Y;
        end
        S_SQ_Y: begin
          d2_q    <= prod_q[DVW-1:0];
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          d2_q <= d2_sum;
          if (d2_sum == '0) begin
            // origin: goal gives no pull, point is skipped
            if (cmd_q == CMD_GOAL) begin
              goal_flag_q <= 1'b1;
            end else begin
              sat_flag_q <= 1'b1;
            end
            state_q <= last_q ? S_CLAMP : S_IDLE;
          end else begin
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (unit_done) begin
            dd_q    <= unit_q[ROOT_BITS-1:0];
            sel_q   <= 1'b0;
            state_q <= S_DIV_U_GO;
          end
        end
        S_DIV_U_GO: begin
          state_q <= S_DIV_U;
        end
        S_DIV_U: begin
          if (unit_done) begin
            ux_q    <= unit_q[UX_BITS-1:0];
            state_q <= S_MUL_G;
          end
        end
        S_MUL_G: begin
          state_q <= S_GAIN;
        end
        S_GAIN, S_DIV_F: begin
          if ((state_q == S_GAIN && cmd_q == CMD_GOAL) || (state_q == S_DIV_F && unit_done)) begin
            if (sel_q) begin
              sum_y_q <= acc_clamped;
            end else begin
              sum_x_q <= acc_clamped;
            end
            if (clip_hi || clip_lo) begin
              sat_flag_q <= 1'b1;
            end
            if (!sel_q) begin
              sel_q   <= 1'b1;
              state_q <= S_DIV_U_GO;
            end else begin
              state_q <= last_q ? S_CLAMP : S_IDLE;
            end
          end else if (state_q == S_GAIN) begin
            state_q <= S_DIV_F;
          end
        end
        S_CLAMP: begin
          rx_q   <= rx_c;
          ry_q   <= ry_c;
          hit_q  <= sat_flag_q || clip_x || clip_y;
          zero_q <= (rx_c == '0) && (ry_c == '0);
          it_q   <= '0;
          // left half plane: rotate by a quarter turn first
          if (rx_c[31]) begin
            if (!ry_c[31]) begin
              cx_q <= CORDIC_BITS'(ry_c);
              cy_q <= -CORDIC_BITS'(rx_c);
              z_q  <= HPI;
            end else begin
              cx_q <= -CORDIC_BITS'(ry_c);
              cy_q <= CORDIC_BITS'(rx_c);
              z_q  <= -HPI;
            end
          end else begin
            cx_q <= CORDIC_BITS'(rx_c);
            cy_q <= CORDIC_BITS'(ry_c);
            z_q  <= '0;
          end
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!cy_q[CORDIC_BITS-1]) begin
            cx_q <= cx_q + sy;
            cy_q <= cy_q - sx;
            z_q  <= z_q + z_step;
          end else begin
            cx_q <= cx_q - sy;
            cy_q <= cy_q + sx;
            z_q  <= z_q - z_step;
          end
          it_q <= it_q + IT_BITS'(1);
          if (it_q == IT_BITS'(CORDIC_STEPS - 1)) begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (zero_q) begin
            h_q <= '0;
          end else if (z_sh > H_HI) begin
            h_q <= H_HI[15:0];
          end else if (z_sh < H_LO) begin
            h_q <= H_LO[15:0];
          end else begin
            h_q <= z_sh[15:0];
          end
          state_q <= S_RATE;
        end
        S_RATE: begin
          state_q <= S_RATE_W;
        end
        S_RATE_W: begin
          rate_q  <= h_q[15] ? -18'(rate_mag) : 18'(rate_mag);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_fx_q     <= rx_q;
            out_fy_q     <= ry_q;
            out_h_q      <= h_q;
            out_rate_q   <= rate_q;
            out_speed_q  <= cruise_speed_q;
            out_status_q <= goal_flag_q ? STATUS_GOAL : (hit_q ? STATUS_SAT : STATUS_OK);
            sum_x_q      <= '0;
            sum_y_q      <= '0;
            goal_flag_q  <= 1'b0;
            sat_flag_q   <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attract_gain_q <= 16'd600;
      repel_gain_q   <= 16'd691;
      turn_gain_q    <= 10'd179;
      cruise_speed_q <= 12'd200;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ATTRACT: attract_gain_q <= cfg_data_i;
        REG_REPEL:   repel_gain_q   <= cfg_data_i;
        REG_TURN:    turn_gain_q    <= cfg_data_i[9:0];
        REG_CRUISE:  cruise_speed_q <= cfg_data_i[11:0];
      endcase
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign force_x_o      = out_fx_q;
  assign force_y_o      = out_fy_q;
  assign heading_o      = out_h_q;
  assign angular_rate_o = out_rate_q;
  assign linear_speed_o = out_speed_q;
  assign status_o       = out_status_q;

endmodule

FILE: rtl/pfs_unit.sv
// shared shift-compare-subtract unit: restoring divide or bit-pair square root
// depends on pfs_pkg
module pfs_unit import pfs_pkg::*; #(
  parameter int NW       = 48,
  parameter int DVW      = 32,
  parameter int SQ_STEPS = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pfs_unit_req_t  req_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DVW-1:0] den_i,
  output logic           done_o,
  output logic [NW-1:0]  q_o
);

  localparam int RW   = DVW + 1;
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   num_q, q_q;
  logic [RW-1:0]   rem_q;
  logic [DVW-1:0]  den_q;
  logic            root_q, busy_q, done_q;
  logic [CNTW-1:0] cnt_q;

  logic [RW-1:0]   rem_sh, trial, rem_nx;
  logic [NW+1:0]   q_ext;
  logic            ge;

  // root mode brings down two radicand bits, trial is 4r+1
  assign q_ext  = {q_q, 2'b01};
  assign rem_sh = root_q ? {rem_q[RW-3:0], num_q[NW-1:NW-2]} : {rem_q[RW-2:0], num_q[NW-1]};
  assign trial  = root_q ? q_ext[RW-1:0] : RW'(den_q);
  assign ge     = rem_sh >= trial;
  assign rem_nx = ge ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      q_q    <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      root_q <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        q_q    <= '0;
        root_q <= req_i.root;
        busy_q <= 1'b1;
        cnt_q  <= req_i.root ? CNTW'(SQ_STEPS) : CNTW'(NW);
      end else if (busy_q) begin
        rem_q <= rem_nx;
        q_q   <= {q_q[NW-2:0], ge};
        num_q <= root_q ? (num_q << 2) : (num_q << 1);
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

FILE: rtl/pfs_checker.sv
// port-level checks for the potential field steering block, bound to the top
// depends on pfs_pkg and potential_field_steering_defines.svh
`include "potential_field_steering_defines.svh"

module pfs_checker import pfs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] force_x_o,
  input logic signed [15:0] heading_o,
  input logic signed [17:0] angular_rate_o,
  input logic [1:0]         status_o
);

  `PFS_ASSERT_IMP(a_status_code, out_valid_o, status_o == STATUS_OK || status_o == STATUS_GOAL || status_o == STATUS_SAT)
  `PFS_ASSERT_IMP(a_heading_range, out_valid_o, heading_o <= 16'sd25736 && heading_o >= -16'sd25736)
  `PFS_ASSERT_IMP(a_zero_turn, out_valid_o && heading_o == 16'sd0, angular_rate_o == 18'sd0)
  `PFS_ASSERT_NXT(a_busy_after_request, in_valid_i && !in_stall_o, in_stall_o)
  `PFS_ASSERT_NXT(a_result_held, out_valid_o && out_stall_i, out_valid_o && $stable(force_x_o))

endmodule

bind potential_field_steering pfs_checker u_pfs_checker (.*);
